### sv/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, constants and helpers for the streaming substring matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Largest pattern the window can hold
  localparam int unsigned PATTERN_MAX_DEF = 16;

  // Field widths fixed by the register map
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned REG_IDX_W = 2;

  // Register indexes (byte address is 8 * index)
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2,
    REG_FOLD_CASE      = 2'd3
  } reg_idx_t;

  // Reset values
  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 5'd1;
  localparam logic             FOLD_CASE_RST      = 1'b1;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [LEN_W-1:0]  pattern_length;
    logic [WORD_W-1:0] pattern_low_bytes;
    logic [WORD_W-1:0] pattern_high_bytes;
    logic              fold_case;
  } cfg_t;

  // One byte request of the stream
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } item_t;

  // Fold ASCII A-Z to lower case when enabled
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                   input logic fold);
    logic [BYTE_W-1:0] r;
    r = b;
    if (fold && (b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

### sv/ssm_cfg_regs.sv
// ----------------------------------------------------------------------------
// ssm_cfg_regs
// APB register file holding pattern length, pattern bytes and fold control.
// ----------------------------------------------------------------------------
module ssm_cfg_regs
  import ssm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length     <= PATTERN_LENGTH_RST;
      cfg.pattern_low_bytes  <= '0;
      cfg.pattern_high_bytes <= '0;
      cfg.fold_case          <= FOLD_CASE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_LENGTH: cfg.pattern_length     <= pwdata[LEN_W-1:0];
        REG_PATTERN_LOW:    cfg.pattern_low_bytes  <= pwdata;
        REG_PATTERN_HIGH:   cfg.pattern_high_bytes <= pwdata;
        REG_FOLD_CASE:      cfg.fold_case          <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PATTERN_LENGTH: prdata = {{(WORD_W-LEN_W){1'b0}}, cfg.pattern_length};
      REG_PATTERN_LOW:    prdata = cfg.pattern_low_bytes;
      REG_PATTERN_HIGH:   prdata = cfg.pattern_high_bytes;
      REG_FOLD_CASE:      prdata = {{(WORD_W-1){1'b0}}, cfg.fold_case};
      default:            prdata = '0;
    endcase
  end

endmodule

### sv/ssm_match_core.sv
// ----------------------------------------------------------------------------
// ssm_match_core
// Sliding byte window, fill count and sticky match flag with parallel compare.
// ----------------------------------------------------------------------------
module ssm_match_core
  import ssm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  advance,
  output logic  file_hit
);

  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [BYTE_W-1:0] window [PATTERN_MAX];
  logic [BYTE_W-1:0] window_next [PATTERN_MAX];
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_count_next;
  logic              match_seen;
  logic              match_base;
  logic              match_seen_next;
  logic [LEN_W-1:0]  len;
  logic [2*WORD_W-1:0] pattern_all;
  logic              eq;
  logic              hit;

  assign pattern_all = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};

  // Clamp pattern length into 1..PATTERN_MAX
  always_comb begin
    priority if (cfg.pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (cfg.pattern_length > LEN_W'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = cfg.pattern_length;
    end
  end

  // Start a new file from a cleared state, shift in the new byte
  always_comb begin
    fill_base  = item.first_byte ? '0 : fill_count;
    match_base = item.first_byte ? 1'b0 : match_seen;
    window_next[0] = item.data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = window[k-1];
    end
    fill_count_next = (fill_base < FILL_W'(PATTERN_MAX)) ? fill_base + FILL_W'(1)
                                                         : fill_base;
  end

  // Compare the newest len window bytes against the pattern
  always_comb begin
    logic [LEN_W-1:0] sel;
    eq = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      sel = len - LEN_W'(1) - LEN_W'(i);
      if (LEN_W'(i) < len) begin
        if (fold_byte(window_next[sel[IDX_W-1:0]], cfg.fold_case) !=
            fold_byte(pattern_all[i*BYTE_W +: BYTE_W], cfg.fold_case)) begin
          eq = 1'b0;
        end
      end
    end
    hit             = eq && (LEN_W'(fill_count_next) >= len);
    match_seen_next = match_base | hit;
  end

  assign file_hit = match_seen_next;

  // Hold window bytes
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  // Advance fill count and match flag; drop them at end of file
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      match_seen <= 1'b0;
    end else if (advance) begin
      if (item.last_byte) begin
        fill_count <= '0;
        match_seen <= 1'b0;
      end else begin
        fill_count <= fill_count_next;
        match_seen <= match_seen_next;
      end
    end
  end

endmodule

### sv/stream_substring_match_unit.sv
// Result path: an accepted last byte request of a file passes the input register,
//   then the result register, and may wait in the input register for out_ready.
// Throughput: one byte per cycle, set by the parallel window compare;
//   a last byte holds the input only while the previous result is still untaken.
// Reset: rst clears the pipeline valids, fill count and match flag, and loads
//   register defaults (length 1, pattern zero, case folding on).
// ----------------------------------------------------------------------------
// stream_substring_match_unit
// Streaming substring detector with an APB configuration port.
// ----------------------------------------------------------------------------
module stream_substring_match_unit
  import ssm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Byte stream
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              first_byte,
  input  logic              last_byte,
  // Result
  output logic              out_valid,
  input  logic              out_ready,
  output logic              file_matched,
  // Configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  logic  s1_advance;
  logic  file_hit;

  ssm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage advances unless its result would overwrite an untaken one
  assign s1_advance = s1_valid && (!s1_item.last_byte || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.data_byte  <= data_byte;
      s1_item.first_byte <= first_byte;
      s1_item.last_byte  <= last_byte;
    end
  end

  ssm_match_core #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (s1_item),
    .advance  (s1_advance),
    .file_hit (file_hit)
  );

  // Result register: load on last byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_item.last_byte) begin
      file_matched <= file_hit;
    end
  end

endmodule
